>>> rtl/srsg_pkg.sv
`timescale 1ns / 1ps
package srsg_pkg;

	localparam int unsigned REVERSE_PAUSE_US_DEF = 5000;
	localparam int unsigned POSITION_BITS_DEF    = 32;

	localparam int unsigned DIV_W   = 64;
	localparam int unsigned DEN_W   = 43;
	localparam int unsigned CNT_W   = 6;
	localparam int unsigned SPEED_W = 19;

	localparam logic [SPEED_W-1:0] SPEED_MIN_Q8   = 19'd256;
	localparam logic [SPEED_W-1:0] SPEED_MAX_Q8   = 19'd307200;
	localparam logic [33:0]        INTERVAL_NUM   = 34'd15360000000;
	localparam logic [DEN_W-1:0]   RAMP_DEN       = 43'd1000000;
	localparam logic [CNT_W-1:0]   RAMP_DIV_BITS  = 6'd56;
	localparam logic [CNT_W-1:0]   IVAL_DIV_BITS  = 6'd34;

	localparam logic [2:0] REG_TARGET = 3'd0;
	localparam logic [2:0] REG_ACCEL  = 3'd1;
	localparam logic [2:0] REG_STEPS  = 3'd2;
	localparam logic [2:0] REG_MICRO  = 3'd3;
	localparam logic [2:0] REG_FOREVR = 3'd4;
	localparam logic [2:0] REG_CW     = 3'd5;

	localparam logic OP_TICK = 1'b0;
	localparam logic OP_MOVE = 1'b1;

	typedef struct packed {
		logic               operation;
		logic [31:0]        now_us;
		logic signed [31:0] step_delta;
	} in_t;

	typedef struct packed {
		logic               step_pulse;
		logic               direction;
		logic               direction_changed;
		logic signed [31:0] position;
		logic [31:0]        interval_us;
	} out_t;

	typedef struct packed {
		logic             start;
		logic [DIV_W-1:0] num;
		logic [DEN_W-1:0] den;
		logic [CNT_W-1:0] nbits;
	} div_req_t;

	typedef struct packed {
		logic             busy;
		logic             done;
		logic [DIV_W-1:0] quo;
	} div_rsp_t;

endpackage

>>> rtl/srsg_div.sv
`timescale 1ns / 1ps
module srsg_div
	import srsg_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic [DEN_W:0]   rem_q;
	logic [DIV_W-1:0] num_q;
	logic [DIV_W-1:0] quo_q;
	logic [DEN_W-1:0] den_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DEN_W:0]   rem_sh;
	logic             fit;

	assign rem_sh = {rem_q[DEN_W-1:0], num_q[DIV_W-1]};
	assign fit    = rem_sh >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= req.nbits;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			num_q <= req.num;
			quo_q <= '0;
			den_q <= req.den;
		end else if (busy_q) begin
			rem_q <= fit ? rem_sh - {1'b0, den_q} : rem_sh;
			num_q <= {num_q[DIV_W-2:0], 1'b0};
			quo_q <= {quo_q[DIV_W-2:0], fit};
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;

endmodule

>>> rtl/stepper_ramp_step_generator_unit.sv
`timescale 1ns / 1ps
// channel   direction  handshake             payload
// in        input      in_valid / in_ready   in_data   (in_t)
// out       output     out_valid / out_ready out_data  (out_t)
// cfg       input      cfg_we                cfg_index, cfg_wdata
//
// A service tick holds the block from its transfer to the result through S_MP, S_IS, S_IW,
// S_MA, S_MB, S_VS, S_VW and S_FN, a move through S_MA to S_FN; the bit-serial divider sets
// the waits in S_IW and S_VW (56 quotient bits for the ramp step, 34 for the step interval).
// One item is in work at a time; a full result register holds the last step.
// Reset loads default configuration and state values and clears handshake flags; data registers load before use.
module stepper_ramp_step_generator_unit
	import srsg_pkg::*;
#(
	parameter int unsigned REVERSE_PAUSE_US = REVERSE_PAUSE_US_DEF,
	parameter int unsigned POSITION_BITS    = POSITION_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  in_t         in_data,
	output logic        out_valid,
	input  logic        out_ready,
	output out_t        out_data,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [18:0] cfg_wdata
);

	localparam int unsigned PB = POSITION_BITS;
	localparam logic [31:0] PAUSE = 32'(REVERSE_PAUSE_US);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_MP   = 4'd1;
	localparam logic [3:0] S_IS   = 4'd2;
	localparam logic [3:0] S_IW   = 4'd3;
	localparam logic [3:0] S_MA   = 4'd4;
	localparam logic [3:0] S_MB   = 4'd5;
	localparam logic [3:0] S_VS   = 4'd6;
	localparam logic [3:0] S_VW   = 4'd7;
	localparam logic [3:0] S_FN   = 4'd8;

	logic [3:0]  state_q;
	logic [18:0] target_q;
	logic [15:0] accel_q;
	logic [15:0] steps_q;
	logic [7:0]  micro_q;
	logic        forever_q;
	logic        cw_q;

	logic [18:0]   speed_q;
	logic [PB-1:0] goal_q;
	logic [PB-1:0] pos_q;
	logic [31:0]   last_step_q;
	logic [31:0]   last_tick_q;
	logic          tick_seen_q;
	logic          dir_q;
	logic          pause_q;

	logic          move_q;
	logic [31:0]   now_q;
	logic [31:0]   dt_q;
	logic [47:0]   prod_q;
	logic [34:0]   m1_q;
	logic [42:0]   den_q;
	logic [31:0]   iv_q;
	logic          out_valid_q;
	out_t          out_q;

	div_req_t div_req;
	div_rsp_t div_rsp;

	srsg_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_comb begin
		div_req.start = (state_q == S_IS) || (state_q == S_VS);
		if (state_q == S_IS) begin
			div_req.num   = {prod_q, 16'b0};
			div_req.den   = RAMP_DEN;
			div_req.nbits = RAMP_DIV_BITS;
		end else begin
			div_req.num   = {INTERVAL_NUM, 30'b0};
			div_req.den   = den_q;
			div_req.nbits = IVAL_DIV_BITS;
		end
	end

	logic [18:0] tgt;
	logic [18:0] diff;
	logic [55:0] inc;
	assign tgt  = (target_q < SPEED_MIN_Q8) ? SPEED_MIN_Q8 :
		(target_q > SPEED_MAX_Q8) ? SPEED_MAX_Q8 : target_q;
	assign diff = (tgt >= speed_q) ? tgt - speed_q : speed_q - tgt;
	assign inc  = div_rsp.quo[55:0];

	logic [33:0] qv;
	logic [31:0] iv_c;
	assign qv   = div_rsp.quo[33:0];
	assign iv_c = (den_q == '0) ? 32'hFFFFFFFF : (qv[33:32] != 2'b0) ? 32'hFFFFFFFF :
		(qv == '0) ? 32'd1 : qv[31:0];

	logic        pause_hold;
	logic [31:0] ls_eff;
	logic        need;
	logic        due;
	logic        dir_new;
	logic        step_go;
	logic        flip_go;
	logic [PB-1:0] pos_nxt;
	logic [PB-1:0] pos_out;
	logic [63:0] pos_ext;
	logic signed [63:0] delta64;
	assign pause_hold = pause_q && ((now_q - last_step_q) < PAUSE);
	assign ls_eff     = pause_q ? last_step_q + PAUSE : last_step_q;
	assign need       = forever_q || (pos_q != goal_q);
	assign due        = need && ((now_q - ls_eff) >= iv_q);
	assign dir_new    = forever_q ? cw_q : ($signed(goal_q) > $signed(pos_q));
	assign step_go    = !move_q && !pause_hold && due && (dir_new == dir_q);
	assign flip_go    = !move_q && !pause_hold && due && (dir_new != dir_q);
	assign pos_nxt    = dir_new ? pos_q + 1'b1 : pos_q - 1'b1;
	assign pos_out    = step_go ? pos_nxt : pos_q;
	assign pos_ext    = 64'(pos_out);
	assign delta64    = 64'(in_data.step_delta);

	logic fin_go;
	assign fin_go = (state_q == S_FN) && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q  <= 19'd15360;
			accel_q   <= 16'd600;
			steps_q   <= 16'd200;
			micro_q   <= 8'd16;
			forever_q <= 1'b0;
			cw_q      <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_TARGET: target_q  <= cfg_wdata;
				REG_ACCEL:  accel_q   <= cfg_wdata[15:0];
				REG_STEPS:  steps_q   <= cfg_wdata[15:0];
				REG_MICRO:  micro_q   <= cfg_wdata[7:0];
				REG_FOREVR: forever_q <= cfg_wdata[0];
				REG_CW:     cw_q      <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			speed_q     <= 19'd15360;
			goal_q      <= '0;
			pos_q       <= '0;
			last_step_q <= '0;
			last_tick_q <= '0;
			tick_seen_q <= 1'b0;
			dir_q       <= 1'b1;
			pause_q     <= 1'b0;
			move_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (fin_go) out_valid_q <= 1'b1;
			else if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						move_q <= in_data.operation;
						if (in_data.operation == OP_MOVE) begin
							goal_q  <= goal_q + delta64[PB-1:0];
							state_q <= S_MA;
						end else begin
							tick_seen_q <= 1'b1;
							last_tick_q <= in_data.now_us;
							state_q     <= S_MP;
						end
					end
				end
				S_MP: state_q <= S_IS;
				S_IS: state_q <= S_IW;
				S_IW: begin
					if (div_rsp.done) begin
						if (56'(diff) < inc) speed_q <= tgt;
						else if (tgt > speed_q) speed_q <= speed_q + inc[18:0];
						else if (tgt < speed_q) speed_q <= speed_q - inc[18:0];
						state_q <= S_MA;
					end
				end
				S_MA: state_q <= S_MB;
				S_MB: state_q <= S_VS;
				S_VS: state_q <= S_VW;
				S_VW: if (div_rsp.done) state_q <= S_FN;
				S_FN: begin
					if (fin_go) begin
						state_q <= S_IDLE;
						if (!move_q && !pause_hold) begin
							pause_q     <= flip_go;
							last_step_q <= due ? now_q : ls_eff;
							if (flip_go) begin
								dir_q   <= dir_new;
								speed_q <= '0;
							end
							if (step_go) pos_q <= pos_nxt;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			now_q <= in_data.now_us;
			dt_q  <= tick_seen_q ? in_data.now_us - last_tick_q : 32'd0;
		end
		if (state_q == S_MP) prod_q <= 48'(accel_q) * 48'(dt_q);
		if (state_q == S_MA) m1_q <= 35'(speed_q) * 35'(steps_q);
		if (state_q == S_MB) den_q <= 43'(m1_q) * 43'(micro_q);
		if (state_q == S_VW && div_rsp.done) iv_q <= iv_c;
		if (fin_go) begin
			out_q.interval_us       <= iv_q;
			out_q.position          <= pos_ext[31:0];
			out_q.direction         <= flip_go ? dir_new : dir_q;
			out_q.step_pulse        <= step_go;
			out_q.direction_changed <= flip_go;
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

>>> rtl/srsg_chk.sv
`timescale 1ns / 1ps
module srsg_chk
	import srsg_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input out_t out_data
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	a_one_at_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second item taken while busy");

	a_iv_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.interval_us != 32'd0)
		else $error("zero interval");

	a_pulse_flip: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(out_data.step_pulse && out_data.direction_changed))
		else $error("step during reversal");

endmodule

bind stepper_ramp_step_generator_unit srsg_chk u_srsg_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);

>>> tb/stepper_ramp_step_generator_unit_tb.sv
`timescale 1ns / 1ps
module stepper_ramp_step_generator_unit_tb;
	import srsg_pkg::*;

	localparam int unsigned PAUSE_US = REVERSE_PAUSE_US_DEF;
	localparam int unsigned STALL_LIMIT = 20000;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	in_t in_data;
	logic out_valid;
	logic out_ready;
	out_t out_data;
	logic cfg_we;
	logic [2:0] cfg_index;
	logic [18:0] cfg_wdata;

	int unsigned mismatches;
	int unsigned send_idle_pct;
	int unsigned recv_idle_pct;
	bit holdoff;
	bit timed_out;
	int unsigned quiet_cycles;

	// configuration and state shadow of the block
	logic [18:0] tgt_speed;
	logic [15:0] accel;
	logic [15:0] steps_rev;
	logic [7:0] micro;
	logic forever_run;
	logic cw_cont;
	logic [18:0] speed;
	logic [31:0] goal_pos;
	logic [31:0] step_pos;
	logic [31:0] last_step_us;
	logic [31:0] last_tick_us;
	logic tick_seen;
	logic prev_dir;
	logic pause_on;
	logic [31:0] clock_us;

	task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
		mismatches++;
		$display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
	endtask

	class step_scoreboard;
		out_t pending[$];

		function void note_transfer(out_t want);
			pending.push_back(want);
		endfunction

		task check_result(out_t got);
			out_t want;
			if (pending.size() == 0) begin
				report("unexpected result", 64'(got.interval_us), 64'(0));
				return;
			end
			want = pending.pop_front();
			if (got.step_pulse !== want.step_pulse)
				report("step_pulse", 64'(got.step_pulse), 64'(want.step_pulse));
			if (got.direction !== want.direction)
				report("direction", 64'(got.direction), 64'(want.direction));
			if (got.direction_changed !== want.direction_changed)
				report("direction_changed", 64'(got.direction_changed),
					64'(want.direction_changed));
			if (got.position !== want.position)
				report("position", 64'(got.position), 64'(want.position));
			if (got.interval_us !== want.interval_us)
				report("interval_us", 64'(got.interval_us), 64'(want.interval_us));
		endtask
	endclass

	step_scoreboard board;

	stepper_ramp_step_generator_unit dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
	);

	function automatic logic [31:0] step_interval(input logic [18:0] spd);
		logic [63:0] den;
		logic [63:0] q;
		den = 64'(spd) * 64'(steps_rev) * 64'(micro);
		if (den == 0) return 32'hFFFF_FFFF;
		q = 64'd15360000000 / den;
		if (q > 64'hFFFF_FFFF) return 32'hFFFF_FFFF;
		if (q == 0) return 32'd1;
		return q[31:0];
	endfunction

	function automatic out_t predict_step(input in_t item);
		out_t res;
		logic [31:0] dt;
		logic [18:0] tgt;
		logic [18:0] diff;
		logic [63:0] inc;
		logic [31:0] iv;
		logic dir;
		res = '0;
		if (item.operation == OP_MOVE) begin
			goal_pos = goal_pos + item.step_delta;
			res.direction = prev_dir;
			res.position = step_pos;
			res.interval_us = step_interval(speed);
			return res;
		end
		dt = tick_seen ? item.now_us - last_tick_us : 32'd0;
		tick_seen = 1'b1;
		last_tick_us = item.now_us;
		tgt = (tgt_speed < SPEED_MIN_Q8) ? SPEED_MIN_Q8 :
			(tgt_speed > SPEED_MAX_Q8) ? SPEED_MAX_Q8 : tgt_speed;
		inc = (64'(accel) * 64'(dt) * 64'd256) / 64'd1000000;
		diff = (tgt >= speed) ? tgt - speed : speed - tgt;
		if (64'(diff) < inc) speed = tgt;
		else if (tgt > speed) speed = speed + inc[18:0];
		else if (tgt < speed) speed = speed - inc[18:0];
		iv = step_interval(speed);
		res.interval_us = iv;
		res.direction = prev_dir;
		res.position = step_pos;
		if (pause_on) begin
			if (item.now_us - last_step_us < PAUSE_US) return res;
			pause_on = 1'b0;
			last_step_us = last_step_us + PAUSE_US;
		end
		if (!(forever_run || step_pos != goal_pos) || item.now_us - last_step_us < iv)
			return res;
		dir = forever_run ? cw_cont : ($signed(goal_pos) > $signed(step_pos));
		if (dir != prev_dir) begin
			prev_dir = dir;
			speed = '0;
			pause_on = 1'b1;
			last_step_us = item.now_us;
			res.direction = dir;
			res.direction_changed = 1'b1;
			return res;
		end
		step_pos = dir ? step_pos + 1 : step_pos - 1;
		last_step_us = item.now_us;
		res.step_pulse = 1'b1;
		res.position = step_pos;
		return res;
	endfunction

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic write_reg(input logic [2:0] idx, input logic [18:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_TARGET: tgt_speed = val;
			REG_ACCEL: accel = val[15:0];
			REG_STEPS: steps_rev = val[15:0];
			REG_MICRO: micro = val[7:0];
			REG_FOREVR: forever_run = val[0];
			REG_CW: cw_cont = val[0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic send_item(input in_t item);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= item;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		board.note_transfer(predict_step(item));
	endtask

	task automatic send_tick(input logic [31:0] adv);
		in_t item;
		clock_us = clock_us + adv;
		item.operation = OP_TICK;
		item.now_us = clock_us;
		item.step_delta = $urandom;
		send_item(item);
	endtask

	task automatic send_move(input logic [31:0] delta);
		in_t item;
		item.operation = OP_MOVE;
		item.now_us = $urandom;
		item.step_delta = delta;
		send_item(item);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (board.pending.size() != 0 && !timed_out) @(posedge clk);
		repeat (120) @(posedge clk);
	endtask

	task automatic random_config();
		case ($urandom_range(3))
			0: write_reg(REG_TARGET, 19'($urandom_range(307200, 256)));
			1: write_reg(REG_TARGET, 19'($urandom));
			default: write_reg(REG_TARGET, 19'($urandom_range(4000, 256)));
		endcase
		write_reg(REG_ACCEL, ($urandom_range(3) == 0) ? 19'(16'($urandom)) :
			19'($urandom_range(3000)));
		write_reg(REG_STEPS, ($urandom_range(7) == 0) ? 19'(16'($urandom)) :
			19'($urandom_range(400)));
		write_reg(REG_MICRO, 19'(8'($urandom)));
		write_reg(REG_FOREVR, 19'($urandom_range(3) == 0));
		write_reg(REG_CW, 19'($urandom_range(1)));
	endtask

	task automatic random_phase(input int unsigned count);
		int unsigned k;
		for (k = 0; k < count; k++) begin
			case ($urandom_range(9))
				0: send_move($urandom);
				1, 2: send_move(32'($signed($urandom_range(40)) - 20));
				3: send_tick($urandom);
				4: send_tick($urandom_range(PAUSE_US + 200, PAUSE_US - 200));
				default: send_tick($urandom_range(20000));
			endcase
		end
	endtask

	always @(posedge clk) begin
		if (out_valid && out_ready) board.check_result(out_data);
		out_ready <= !holdoff && ($urandom_range(99) >= recv_idle_pct);
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || board.pending.size() == 0)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > STALL_LIMIT && !timed_out) begin
			timed_out = 1'b1;
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		board = new();
		mismatches = 0;
		timed_out = 1'b0;
		quiet_cycles = 0;
		holdoff = 1'b0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_ready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_TARGET;
		cfg_wdata = '0;
		tgt_speed = 19'd15360;
		accel = 16'd600;
		steps_rev = 16'd200;
		micro = 8'd16;
		forever_run = 1'b0;
		cw_cont = 1'b1;
		speed = 19'd15360;
		goal_pos = '0;
		step_pos = '0;
		last_step_us = '0;
		last_tick_us = '0;
		tick_seen = 1'b0;
		prev_dir = 1'b1;
		pause_on = 1'b0;
		clock_us = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset values, first tick, extremes, flips, pause
		send_tick(32'hFFFF_FF00);
		send_move(32'sh7FFF_FFFF);
		send_move(32'sh8000_0001);
		send_move(3);
		send_tick(32'hFFFF_FFFF);
		send_tick(100000);
		send_tick(100000);
		send_move(-10);
		send_tick(50000);
		send_tick(1000);
		send_tick(6000);
		send_tick(100000);
		send_tick(0);
		drain();
		write_reg(REG_TARGET, 19'd0);
		write_reg(REG_ACCEL, 19'h0FFFF);
		write_reg(REG_STEPS, 19'd0);
		write_reg(REG_MICRO, 19'd0);
		write_reg(REG_FOREVR, 19'd1);
		write_reg(REG_CW, 19'd0);
		send_tick(1000000);
		send_move(32'hFFFF_FFFF);
		drain();
		write_reg(REG_TARGET, 19'h7FFFF);
		write_reg(REG_STEPS, 19'h0FFFF);
		write_reg(REG_MICRO, 19'h000FF);
		write_reg(REG_CW, 19'd1);
		send_tick(1000000);
		send_tick(32'h8000_0000);
		send_tick(10);
		send_tick(10);
		drain();

		send_idle_pct = 28;
		recv_idle_pct = 85;
		random_config();
		random_phase(200);
		drain();
		send_idle_pct = 85;
		recv_idle_pct = 28;
		random_config();
		random_phase(200);
		drain();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		random_config();
		fork
			begin
				holdoff = 1'b1;
				repeat (600) @(posedge clk);
				holdoff = 1'b0;
			end
			random_phase(30);
		join
		random_phase(170);
		drain();
		write_reg(REG_TARGET, 19'd256);
		write_reg(REG_ACCEL, 19'd0);
		write_reg(REG_STEPS, 19'd1);
		write_reg(REG_MICRO, 19'd1);
		write_reg(REG_FOREVR, 19'd0);
		random_phase(150);
		drain();

		if (mismatches == 0 && board.pending.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end
endmodule

>>> filelist.f
rtl/srsg_pkg.sv
rtl/srsg_div.sv
rtl/stepper_ramp_step_generator_unit.sv
rtl/srsg_chk.sv
tb/stepper_ramp_step_generator_unit_tb.sv
